@@ rtl/sra_pkg.sv @@
`timescale 1ns / 1ps

package sra_pkg;

  localparam int DEF_VALUE_BITS  = 32;
  localparam int DEF_MAX_WIDTH   = 64;
  localparam int DEF_QUEUE_DEPTH = 2;

  // Quotient bits resolved per divider cycle.
  localparam int DIV_STEP = 8;

  localparam logic [5:0] RADIX_MIN  = 6'd2;
  localparam logic [5:0] RADIX_MAX  = 6'd36;
  localparam logic [5:0] DIGIT_MAX  = 6'd35;
  localparam logic [5:0] DIGIT_TEN  = 6'd10;
  localparam logic [6:0] CHAR_MINUS = 7'h2d;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h61;

  typedef struct packed {
    logic       negative;
    logic [5:0] radix;
    logic [6:0] width;
  } item_ctl_t;

  function automatic logic [6:0] digit_char(input logic [5:0] d);
    logic [5:0] dc;
    dc = (d > DIGIT_MAX) ? DIGIT_MAX : d;
    if (dc < DIGIT_TEN) begin
      digit_char = CHAR_ZERO + 7'(dc);
    end else begin
      digit_char = CHAR_A + 7'(dc - DIGIT_TEN);
    end
  endfunction

endpackage

@@ rtl/sra_front.sv @@
`timescale 1ns / 1ps

module sra_front
  import sra_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [5:0]            radix,
  input  logic [6:0]            min_width,
  input  logic                  q_full,
  output logic                  busy,
  output logic                  push,
  output logic [VALUE_BITS-1:0] mag,
  output item_ctl_t             ctl
);

  logic negative;

  assign busy     = q_full;
  assign push     = start && !q_full;
  assign negative = value[VALUE_BITS-1];

  // The most negative value negates to itself, which read unsigned is its magnitude.
  assign mag = negative ? (~value + 1'b1) : value;

  always_comb begin
    ctl.negative = negative;
    if (radix < RADIX_MIN) begin
      ctl.radix = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      ctl.radix = RADIX_MAX;
    end else begin
      ctl.radix = radix;
    end
    if (min_width > 7'(MAX_WIDTH)) begin
      ctl.width = 7'(MAX_WIDTH);
    end else begin
      ctl.width = min_width;
    end
  end

endmodule

@@ rtl/sra_queue.sv @@
`timescale 1ns / 1ps

module sra_queue
  import sra_pkg::*;
#(
  parameter int WIDTH = DEF_VALUE_BITS,
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             valid,
  output logic             full,
  output logic [WIDTH-1:0] data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign valid = (count != '0);
  assign full  = (count == CW'(DEPTH));
  assign data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && !valid))
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= CW'(DEPTH)))
    else $error("queue count beyond depth");

endmodule

@@ rtl/sra_back.sv @@
`timescale 1ns / 1ps

module sra_back
  import sra_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  logic [VALUE_BITS-1:0] q_mag,
  input  item_ctl_t             q_ctl,
  output logic                  q_pop,
  output logic [6:0]            char_code,
  output logic                  last,
  output logic                  strobe
);

  localparam int PAD_BITS = ((VALUE_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
  localparam int CHUNKS   = PAD_BITS / DIV_STEP;
  localparam int CW       = $clog2(CHUNKS + 1);
  localparam int AW       = $clog2(VALUE_BITS);
  localparam int DCW      = $clog2(VALUE_BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVIDE,
    S_PREP,
    S_SIGN,
    S_PAD,
    S_DIGIT
  } state_t;

  state_t              state;
  logic [PAD_BITS-1:0] mag;
  logic [5:0]          rem;
  logic [5:0]          radix_r;
  logic [6:0]          width_r;
  logic                negative;
  logic [DCW-1:0]      digit_count;
  logic [CW-1:0]       chunk;
  logic [6:0]          pad_count;
  logic [AW-1:0]       idx;
  logic [AW-1:0]       idx_next;
  logic [5:0]          rd_data;
  logic [5:0]          store [VALUE_BITS];

  logic [PAD_BITS-1:0] mag_step;
  logic [5:0]          rem_step;
  logic                chunk_done;
  logic                store_we;
  logic [6:0]          total;
  logic [6:0]          pad;

  // Restoring division of the top chunk by the radix, one quotient bit per step.
  always_comb begin
    logic [6:0]          r;
    logic [6:0]          t;
    logic [DIV_STEP-1:0] hi;
    logic [DIV_STEP-1:0] q;
    r  = {1'b0, rem};
    hi = mag[PAD_BITS-1 -: DIV_STEP];
    q  = '0;
    for (int i = DIV_STEP - 1; i >= 0; i--) begin
      t = {r[5:0], hi[i]};
      if (t >= {1'b0, radix_r}) begin
        q[i] = 1'b1;
        r    = t - {1'b0, radix_r};
      end else begin
        r = t;
      end
    end
    mag_step = (mag << DIV_STEP) | PAD_BITS'(q);
    rem_step = r[5:0];
  end

  assign chunk_done = (chunk == CW'(CHUNKS - 1));
  assign store_we   = (state == S_DIVIDE) && chunk_done;
  assign total      = 7'(digit_count) + 7'(negative);
  assign pad        = (width_r > total) ? (width_r - total) : '0;
  assign q_pop      = (state == S_IDLE) && q_valid;

  always_comb begin
    case (state)
      S_PREP:  idx_next = AW'(digit_count - 1'b1);
      S_DIGIT: idx_next = idx - 1'b1;
      default: idx_next = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[digit_count[AW-1:0]] <= rem_step;
    end
    rd_data <= store[idx_next];
  end

  always_comb begin
    strobe = (state == S_SIGN) || (state == S_PAD) || (state == S_DIGIT);
    last   = (state == S_DIGIT) && (idx == '0);
    case (state)
      S_SIGN:  char_code = CHAR_MINUS;
      S_PAD:   char_code = CHAR_ZERO;
      S_DIGIT: char_code = digit_char(rd_data);
      default: char_code = CHAR_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      digit_count <= '0;
      chunk       <= '0;
      pad_count   <= '0;
      idx         <= '0;
    end else begin
      idx <= idx_next;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            mag         <= PAD_BITS'(q_mag);
            rem         <= '0;
            radix_r     <= q_ctl.radix;
            width_r     <= q_ctl.width;
            negative    <= q_ctl.negative;
            digit_count <= '0;
            chunk       <= '0;
            state       <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          mag <= mag_step;
          if (chunk_done) begin
            rem         <= '0;
            chunk       <= '0;
            digit_count <= digit_count + 1'b1;
            if ((mag_step == '0) || (digit_count == DCW'(VALUE_BITS - 1))) begin
              state <= S_PREP;
            end
          end else begin
            rem   <= rem_step;
            chunk <= chunk + 1'b1;
          end
        end
        S_PREP: begin
          pad_count <= pad;
          if (negative) begin
            state <= S_SIGN;
          end else if (pad != '0) begin
            state <= S_PAD;
          end else begin
            state <= S_DIGIT;
          end
        end
        S_SIGN: begin
          state <= (pad_count != '0) ? S_PAD : S_DIGIT;
        end
        S_PAD: begin
          pad_count <= pad_count - 1'b1;
          if (pad_count == 7'd1) begin
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (idx == '0) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVIDE) |-> (rem < radix_r))
    else $error("partial remainder not below radix");

  a_pad_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAD) |-> (pad_count != '0))
    else $error("padding state entered with no padding left");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (digit_count <= DCW'(VALUE_BITS)))
    else $error("digit count beyond store depth");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("character emitted right after the final one");

endmodule

@@ rtl/signed_radix_to_ascii_unit.sv @@
`timescale 1ns / 1ps

// One divider resolves 8 quotient bits per cycle and divides the whole value once per digit.
// A number occupies the back end through its division, a preparation state and its N characters,
// which leave one per cycle. A two-word queue lets the next number be accepted while one is being
// converted. Synchronous reset empties the queue and returns the converter to idle; the digit
// store is not cleared. The receiver cannot stall: each character shows for one cycle.

module signed_radix_to_ascii_unit
  import sra_pkg::*;
#(
  parameter int VALUE_BITS  = DEF_VALUE_BITS,
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [5:0]            radix,
  input  logic [6:0]            min_width,
  output logic [6:0]            char_code,
  output logic                  last,
  output logic                  strobe
);

  localparam int QW = VALUE_BITS + $bits(item_ctl_t);

  logic                  push;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic [VALUE_BITS-1:0] f_mag;
  item_ctl_t             f_ctl;
  logic [QW-1:0]         q_data;
  logic [VALUE_BITS-1:0] q_mag;
  item_ctl_t             q_ctl;

  sra_front #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_front (
    .start     (start),
    .value     (value),
    .radix     (radix),
    .min_width (min_width),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .mag       (f_mag),
    .ctl       (f_ctl)
  );

  sra_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({f_mag, f_ctl}),
    .pop       (q_pop),
    .valid     (q_valid),
    .full      (q_full),
    .data      (q_data)
  );

  assign q_mag = q_data[QW-1 -: VALUE_BITS];
  assign q_ctl = q_data[$bits(item_ctl_t)-1:0];

  sra_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_mag     (q_mag),
    .q_ctl     (q_ctl),
    .q_pop     (q_pop),
    .char_code (char_code),
    .last      (last),
    .strobe    (strobe)
  );

endmodule

@@ tb/sv/tb_signed_radix_to_ascii_unit.sv @@
`timescale 1ns / 1ps

typedef struct packed {
  logic [6:0] code;
  logic       last;
} ascii_char_t;

class text_scoreboard;
  ascii_char_t expected_chars[$];
  int          errors = 0;

  // Converts one accepted word into the characters the block must emit.
  function void note_word(logic [31:0] v, logic [5:0] r, logic [6:0] w);
    bit [31:0]   mag;
    bit [31:0]   base;
    int          wd;
    int          nd;
    int          pad;
    int          total;
    int          k;
    bit          neg;
    bit [5:0]    digs[32];
    ascii_char_t c;
    neg  = v[31];
    mag  = neg ? (32'd0 - v) : v;
    base = (r < sra_pkg::RADIX_MIN) ? 32'(sra_pkg::RADIX_MIN) :
           (r > sra_pkg::RADIX_MAX) ? 32'(sra_pkg::RADIX_MAX) : 32'(r);
    wd   = (w > 64) ? 64 : int'(w);
    nd   = 0;
    do begin
      digs[nd] = 6'(mag % base);
      mag      = mag / base;
      nd++;
    end while (mag != 0 && nd < 32);
    total = int'(neg) + nd;
    pad   = (wd > total) ? wd - total : 0;
    total = total + pad;
    k     = 0;
    if (neg) begin
      k++;
      c.code = sra_pkg::CHAR_MINUS;
      c.last = (k == total);
      expected_chars.push_back(c);
    end
    repeat (pad) begin
      k++;
      c.code = sra_pkg::CHAR_ZERO;
      c.last = (k == total);
      expected_chars.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      k++;
      if (digs[i] < sra_pkg::DIGIT_TEN) begin
        c.code = sra_pkg::CHAR_ZERO + 7'(digs[i]);
      end else begin
        c.code = sra_pkg::CHAR_A + 7'(digs[i] - sra_pkg::DIGIT_TEN);
      end
      c.last = (k == total);
      expected_chars.push_back(c);
    end
  endfunction

  function void check_char(logic [6:0] code, logic last);
    ascii_char_t c;
    if (expected_chars.size() == 0) begin
      $display("%0t: unexpected character, expected none, actual code %h last %b",
               $time, code, last);
      errors++;
      return;
    end
    c = expected_chars.pop_front();
    if (code !== c.code) begin
      $display("%0t: char_code expected %h actual %h", $time, c.code, code);
      errors++;
    end
    if (last !== c.last) begin
      $display("%0t: last expected %b actual %b", $time, c.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return expected_chars.size();
  endfunction
endclass

module tb_signed_radix_to_ascii_unit;
  import sra_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_WORDS = 480;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] value = '0;
  logic [5:0]  radix = '0;
  logic [6:0]  min_width = '0;
  logic [6:0]  char_code;
  logic        last;
  logic        strobe;

  text_scoreboard sb;
  int idle_cycles = 0;
  int burst_left = 0;

  signed_radix_to_ascii_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .value(value),
    .radix(radix),
    .min_width(min_width),
    .char_code(char_code),
    .last(last),
    .strobe(strobe)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (start && !busy) begin
        sb.note_word(value, radix, min_width);
      end
      if (strobe) begin
        sb.check_char(char_code, last);
      end
      if ((start && !busy) || strobe) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  task automatic send_word(input logic [31:0] v, input logic [5:0] r, input logic [6:0] w);
    start     <= 1'b1;
    value     <= v;
    radix     <= r;
    min_width <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Sends a word and closes the burst with an idle gap when it runs out.
  task automatic feed(input logic [31:0] v, input logic [5:0] r, input logic [6:0] w);
    send_word(v, r, w);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(-$urandom_range(1, 1000));
      3: return 32'($urandom_range(0, 1000));
      4: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] pick_radix();
    if ($urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(2, 36));
  endfunction

  function automatic logic [6:0] pick_width();
    case ($urandom_range(0, 9))
      0: return 7'($urandom_range(0, 127));
      1: return 7'($urandom_range(30, 70));
      default: return 7'($urandom_range(0, 12));
    endcase
  endfunction

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    feed(32'd0, 6'd10, 7'd0);
    feed(32'd0, 6'd2, 7'd64);
    feed(32'h7fff_ffff, 6'd2, 7'd0);
    feed(32'h8000_0000, 6'd2, 7'd0);
    feed(32'h8000_0000, 6'd36, 7'd0);
    feed(32'h7fff_ffff, 6'd36, 7'd0);
    feed(32'h8000_0000, 6'd16, 7'd64);
    feed(32'hffff_ffff, 6'd10, 7'd5);
    feed(32'hffff_ffff, 6'd2, 7'd1);
    feed(32'hffff_ffff, 6'd2, 7'd2);
    feed(32'd12345, 6'd0, 7'd0);
    feed(32'd12345, 6'd1, 7'd3);
    feed(32'd12345, 6'd37, 7'd0);
    feed(-32'd12345, 6'd63, 7'd127);
    feed(32'd35, 6'd36, 7'd1);
    feed(32'd36, 6'd36, 7'd0);
    feed(32'd100, 6'd10, 7'd3);
    feed(32'd100, 6'd10, 7'd4);
    feed(-32'd100, 6'd10, 7'd4);
    feed(-32'd100, 6'd10, 7'd5);
    feed(32'd255, 6'd16, 7'd65);
    feed(32'd0, 6'd0, 7'd127);
    feed(32'hdead_beef, 6'd8, 7'd64);
    drain();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      feed(pick_value(), pick_radix(), pick_width());
      if (n == RANDOM_WORDS / 2) begin
        drain();
      end
    end
    drain();
    repeat (300) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sra_pkg.sv
rtl/sra_front.sv
rtl/sra_queue.sv
rtl/sra_back.sv
rtl/signed_radix_to_ascii_unit.sv
tb/sv/tb_signed_radix_to_ascii_unit.sv
